[src/mgss_pkg.sv]
`default_nettype none
package mgss_pkg;

  localparam int VAL_W  = 31;  // reduced values stay below 2*modulus
  localparam int MOD_W  = 30;
  localparam int SUM_W  = VAL_W + 1;
  localparam int PROD_W = 2 * VAL_W;
  localparam int MUL_ITERS = PROD_W / 2;
  localparam int ADD_ITERS = SUM_W / 2;
  localparam int ITER_W = $clog2(MUL_ITERS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_START,
    ST_DIV,
    ST_FIN
  } state_t;

  // Micro-ops of one doubling step, issued in this order; OP_T1 to OP_LEAD only for a set count bit
  typedef enum logic [2:0] {
    OP_T1,    // tmp  = lead * blk
    OP_ACC,   // acc  = acc + tmp
    OP_LEAD,  // lead = lead * pw
    OP_T2,    // tmp  = pw + 1
    OP_BLK,   // blk  = blk * tmp
    OP_PW     // pw   = pw * pw
  } op_t;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic wb;
    logic shift_cnt;
    logic load_out;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic cnt_lsb;
    logic cnt_zero;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

[src/mgss_div.sv]
`default_nettype none
module mgss_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        is_add,
  input  wire logic [mgss_pkg::PROD_W-1:0] dividend,
  input  wire logic [mgss_pkg::MOD_W-1:0]  modulus,
  output logic                             done,
  output logic [mgss_pkg::VAL_W-1:0]       result
);
  import mgss_pkg::*;

  logic [PROD_W-1:0] dvd_r, dvd_nxt;
  logic [MOD_W-1:0]  rem_r, rem_nxt;
  logic [ITER_W-1:0] it_r, it_nxt;
  logic              run_r, run_nxt;
  logic              qnz_r, qnz_nxt;

  logic [MOD_W:0] r1, s1, r2, s2, mod_x;
  logic           ge1, ge2;

  // Two restoring steps per cycle
  always_comb begin
    mod_x = {1'b0, modulus};
    r1    = {rem_r, dvd_r[PROD_W-1]};
    ge1   = (r1 >= mod_x);
    s1    = ge1 ? (r1 - mod_x) : r1;
    r2    = {s1[MOD_W-1:0], dvd_r[PROD_W-2]};
    ge2   = (r2 >= mod_x);
    s2    = ge2 ? (r2 - mod_x) : r2;
  end

  assign done   = run_r && (it_r == '0);
  // exact when below modulus, else modulus plus residue
  assign result = qnz_r ? (VAL_W'(modulus) + VAL_W'(rem_r)) : VAL_W'(rem_r);

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    it_nxt  = it_r;
    run_nxt = run_r;
    qnz_nxt = qnz_r;
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      it_nxt  = is_add ? ITER_W'(ADD_ITERS) : ITER_W'(MUL_ITERS);
      run_nxt = 1'b1;
      qnz_nxt = 1'b0;
    end else if (done) begin
      run_nxt = 1'b0;
    end else if (run_r) begin
      dvd_nxt = {dvd_r[PROD_W-3:0], 2'b00};
      rem_nxt = s2[MOD_W-1:0];
      it_nxt  = it_r - 1'b1;
      qnz_nxt = qnz_r | ge1 | ge2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      it_r  <= '0;
    end else begin
      run_r <= run_nxt;
      it_r  <= it_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    qnz_r <= qnz_nxt;
  end

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r) else $error("divider restarted while busy");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (rem_r < modulus)) else $error("partial remainder out of range");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("divider done held");
`endif

endmodule
`default_nettype wire

[src/mgss_datapath.sv]
`default_nettype none
module mgss_datapath #(
  parameter int COUNT_BITS = 31
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mgss_pkg::cmd_t             cmd,
  output mgss_pkg::sts_t                  sts,
  input  wire logic [30:0]                in_base,
  input  wire logic [30:0]                in_term_count,
  input  wire logic [mgss_pkg::MOD_W-1:0] in_modulus,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [mgss_pkg::VAL_W-1:0]      out_series_sum
);
  import mgss_pkg::*;

  logic [VAL_W-1:0]      pw_r, lead_r, blk_r, acc_r, tmp_r;
  logic [MOD_W-1:0]      m_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  out_valid_r;
  logic [VAL_W-1:0]      out_sum_r;

  logic [VAL_W-1:0]  mul_a, mul_b, add_a, add_b, red;
  logic              is_add, div_done;
  logic [PROD_W-1:0] prod, dividend;
  logic [SUM_W-1:0]  sum;

  always_comb begin
    mul_a  = lead_r;
    mul_b  = blk_r;
    add_a  = acc_r;
    add_b  = tmp_r;
    is_add = 1'b0;
    unique case (cmd.op)
      OP_T1:   begin mul_a = lead_r; mul_b = blk_r; end
      OP_ACC:  begin add_a = acc_r; add_b = tmp_r; is_add = 1'b1; end
      OP_LEAD: begin mul_a = lead_r; mul_b = pw_r; end
      OP_T2:   begin add_a = pw_r; add_b = VAL_W'(1); is_add = 1'b1; end
      OP_BLK:  begin mul_a = blk_r; mul_b = tmp_r; end
      OP_PW:   begin mul_a = pw_r; mul_b = pw_r; end
      default: ;
    endcase
  end

  assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign sum      = SUM_W'(add_a) + SUM_W'(add_b);
  // sums go in left-aligned so the divider only walks their bits
  assign dividend = is_add ? {sum, (PROD_W - SUM_W)'(0)} : prod;

  mgss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .is_add   (is_add),
    .dividend (dividend),
    .modulus  (m_r),
    .done     (div_done),
    .result   (red)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pw_r   <= in_base;
      lead_r <= VAL_W'(1);
      blk_r  <= VAL_W'(1);
      acc_r  <= '0;
      m_r    <= (in_modulus == '0) ? MOD_W'(1) : in_modulus;
      cnt_r  <= COUNT_BITS'(in_term_count);
    end else begin
      if (cmd.wb) begin
        unique case (cmd.op)
          OP_T1:   tmp_r  <= red;
          OP_ACC:  acc_r  <= red;
          OP_LEAD: lead_r <= red;
          OP_T2:   tmp_r  <= red;
          OP_BLK:  blk_r  <= red;
          OP_PW:   pw_r   <= red;
          default: ;
        endcase
      end
      if (cmd.shift_cnt) begin
        cnt_r <= cnt_r >> 1;
      end
    end
    if (cmd.load_out) begin
      out_sum_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_series_sum = out_sum_r;

  always_comb begin
    sts.cnt_lsb  = cnt_r[0];
    sts.cnt_zero = (cnt_r == '0);
    sts.div_done = div_done;
    sts.out_busy = out_valid_r && out_stall;
  end

`ifndef ASSERT_OFF
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");
  a_wb_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |-> div_done) else $error("write-back without divider result");
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !cmd.load_in && !cmd.wb)
    else $error("divider start collides with load or write-back");
`endif

endmodule
`default_nettype wire

[src/mgss_ctrl.sv]
`default_nettype none
module mgss_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire mgss_pkg::sts_t sts,
  output mgss_pkg::cmd_t      cmd
);
  import mgss_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_T1;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    in_stall      = 1'b1;
    cmd.load_in   = 1'b0;
    cmd.div_start = 1'b0;
    cmd.wb        = 1'b0;
    cmd.shift_cnt = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.op        = op_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CHK;
        end
      end
      ST_CHK: begin
        // no set bits left: the sum is complete
        if (sts.cnt_zero) begin
          state_nxt = ST_FIN;
        end else begin
          op_nxt    = sts.cnt_lsb ? OP_T1 : OP_T2;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.wb    = 1'b1;
          state_nxt = ST_START;
          unique case (op_r)
            OP_T1:   op_nxt = OP_ACC;
            OP_ACC:  op_nxt = OP_LEAD;
            OP_LEAD: op_nxt = OP_T2;
            OP_T2:   op_nxt = OP_BLK;
            OP_BLK:  op_nxt = OP_PW;
            OP_PW: begin
              cmd.shift_cnt = 1'b1;
              state_nxt     = ST_CHK;
            end
            default: state_nxt = ST_CHK;
          endcase
        end
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_start_then_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_START |=> state_r == ST_DIV) else $error("start not followed by wait");
  a_shift_after_pw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_cnt |-> op_r == OP_PW) else $error("count shifted mid-step");
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> state_r == ST_IDLE) else $error("result loaded outside finish");
`endif

endmodule
`default_nettype wire

[src/modular_geometric_series_sum.sv]
`default_nettype none
// Modular geometric series sum: series_sum = sum of base^i, i = 0 .. term_count-1,
// with every add and multiply reduced as "exact below modulus, else modulus plus
// residue", so the result lies in [0, 2*modulus). A term count of zero gives 0,
// a modulus of zero acts as one, and only the low COUNT_BITS bits of the count count.
// Input channel in_*, result channel out_*: valid/stall, an item moves on a clock
// edge with valid high and stall low. One item is worked on at a time; in_stall is
// low only while the block is idle.
// Operation: the count is walked by doubling from its lsb up to its highest set bit;
// a clear bit skips the accumulate micro-ops. Nearly all the time is spent in the
// shared remainder unit (2 bits a cycle), which reduces each product and each sum
// in turn, with a start and a write-back step for each.
// The result waits in an output register; while out_stall is high it holds, and
// the next item may be taken meanwhile. A second result waits for that register.
// Reset (synchronous, active low) drops any item in flight and clears out_valid.
module modular_geometric_series_sum #(
  parameter int COUNT_BITS = 31
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [30:0]                in_base,
  input  wire logic [30:0]                in_term_count,
  input  wire logic [mgss_pkg::MOD_W-1:0] in_modulus,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [mgss_pkg::VAL_W-1:0]      out_series_sum
);
  import mgss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mgss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mgss_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_base        (in_base),
    .in_term_count  (in_term_count),
    .in_modulus     (in_modulus),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_series_sum (out_series_sum)
  );

endmodule
`default_nettype wire
